// File: hdl/lerq_pkg.sv
// Shared types, constants and codes for the LOOK elevator request scheduler.
// Depends on nothing; every other file in this folder imports it.
package lerq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TRACK_LIMIT = 1024;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TRACK_W     = 10;
   localparam int SECTOR_W    = 8;
   localparam int TAG_W       = 8;
   localparam int STATUS_W    = 2;

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_SERVICE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [TRACK_W:0] TRACK_MAX = 11'(TRACK_LIMIT - 1);

   typedef struct packed {
      logic                command;
      logic [TRACK_W-1:0]  track;
      logic [SECTOR_W-1:0] sector;
      logic [TAG_W-1:0]    request_tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TRACK_W-1:0]  served_track;
      logic [SECTOR_W-1:0] served_sector;
      logic [TAG_W-1:0]    served_tag;
      logic                turned;
      logic [CNT_W-1:0]    pending;
   } rsp_type;

   typedef struct packed {
      logic [TRACK_W-1:0]  track;
      logic [SECTOR_W-1:0] sector;
      logic [TAG_W-1:0]    tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD_NEW,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_op_type;

   typedef struct packed {
      logic               occupied;
      logic [TRACK_W-1:0] key;
   } cell_ctrl_type;

   function automatic logic [TRACK_W-1:0] sat_track(input logic [TRACK_W-1:0] trk);
      logic [TRACK_W:0] wide;
      wide = {1'b0, trk};
      if (wide > TRACK_MAX) begin
         return TRACK_MAX[TRACK_W-1:0];
      end
      return trk;
   endfunction

endpackage

// File: hdl/look_elevator_request_scheduler.sv
// Top level of the LOOK elevator request scheduler: sweep control over a row of cells.
// Depends on lerq_pkg and lerq_cell.
//
// Usage: a beat on the request side is taken at a rising edge where start is high
// and busy is low. req_data.command selects insert (track, sector and tag are
// stored in track order) or service (the entry at the current sweep position is
// handed out and removed). Every accepted beat yields exactly one result beat,
// presented on rsp_data with rsp_strobe high for one cycle, in the cycle after the
// request was taken. The receiver cannot stall, so the result is simply gone
// after that cycle. busy stays low: every cell compares its own track against the new
// one and all cells shift together, so a new request may be given in every cycle.
// The status field reports done, insert into a full store, or service on an
// empty store; the rejected cases change nothing. pending gives the number of
// stored requests after the beat, and turned marks a service that reversed the
// sweep. A synchronous reset empties the store and sets the sweep ascending;
// slot contents are not cleared and are never read before being written.
module look_elevator_request_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lerq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lerq_pkg::rsp_type rsp_data
);
   import lerq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             up_ff, up_in;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff, rsp_in;

   entry_type     cell_entry [QUEUE_DEPTH];
   logic          cell_below [QUEUE_DEPTH];
   cell_ctrl_type cell_ctrl  [QUEUE_DEPTH];
   cell_op_type   cell_op    [QUEUE_DEPTH];
   entry_type     new_entry;
   entry_type     served;

   logic             accept;
   logic             full;
   logic             empty;
   logic [CNT_W-1:0] pos_sum;
   logic [IDX_W-1:0] pos;
   logic [IDX_W-1:0] cur_eff;
   logic [CNT_W-1:0] count_dec;
   logic             off_end;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign count_dec = count_ff - CNT_W'(1);

   assign new_entry.track  = sat_track(req_data.track);
   assign new_entry.sector = req_data.sector;
   assign new_entry.tag    = req_data.request_tag;

   always_comb begin
      pos_sum = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         pos_sum = pos_sum + CNT_W'(cell_below[i]);
      end
   end
   assign pos = pos_sum[IDX_W-1:0];

   always_comb begin
      if ({1'b0, cur_ff} >= count_ff) begin
         cur_eff = count_dec[IDX_W-1:0];
      end else begin
         cur_eff = cur_ff;
      end
   end

   assign served  = cell_entry[cur_eff];
   assign off_end = up_ff ? ({1'b0, cur_eff} + CNT_W'(1) >= count_ff) : (cur_eff == '0);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_ctrl[i].occupied = (CNT_W'(i) < count_ff);
         cell_ctrl[i].key      = new_entry.track;
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_op[i] = CELL_HOLD;
         if (accept) begin
            if (req_data.command == CMD_INSERT) begin
               if (!full) begin
                  if (IDX_W'(i) > pos) begin
                     cell_op[i] = CELL_FROM_LEFT;
                  end else if (IDX_W'(i) == pos) begin
                     cell_op[i] = CELL_LOAD_NEW;
                  end
               end
            end else if (!empty && IDX_W'(i) >= cur_eff) begin
               cell_op[i] = CELL_FROM_RIGHT;
            end
         end
      end
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_type left_e, right_e;
      if (g == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_mid_l
         assign left_e = cell_entry[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_mid_r
         assign right_e = cell_entry[g+1];
      end
      lerq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[g]),
         .op          (cell_op[g]),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (cell_entry[g]),
         .below       (cell_below[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      cur_in   = cur_ff;
      up_in    = up_ff;
      rsp_in   = '0;
      if (req_data.command == CMD_INSERT) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
            if (empty) begin
               cur_in = '0;
            end else if (pos <= cur_ff) begin
               cur_in = cur_ff + IDX_W'(1);
            end
         end
      end else begin
         if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.served_track  = served.track;
            rsp_in.served_sector = served.sector;
            rsp_in.served_tag    = served.tag;
            count_in = count_dec;
            if (off_end) begin
               rsp_in.turned = 1'b1;
               up_in = !up_ff;
               if (!up_ff || count_dec == '0) begin
                  cur_in = '0;
               end else begin
                  cur_in = IDX_W'(count_dec - CNT_W'(1));
               end
            end else begin
               cur_in = up_ff ? cur_eff : cur_eff - IDX_W'(1);
            end
         end
      end
      rsp_in.pending = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cur_ff        <= '0;
         up_ff         <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
            cur_ff   <= cur_in;
            up_ff    <= up_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("Accepted beat produced no result.");

   a_pending_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.pending == count_ff)
      else $error("Reported pending count disagrees with the store.");

   a_reject_static: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_DONE) |-> $stable(count_ff))
      else $error("Rejected beat changed the entry count.");

endmodule

// File: hdl/lerq_cell.sv
// One slot of the sorted request row: holds an entry and shifts with its neighbors.
// Depends on lerq_pkg for the entry and control types.
module lerq_cell (
   input  logic                    clock,
   input  lerq_pkg::cell_ctrl_type ctrl,
   input  lerq_pkg::cell_op_type   op,
   input  lerq_pkg::entry_type     new_entry,
   input  lerq_pkg::entry_type     left_entry,
   input  lerq_pkg::entry_type     right_entry,
   output lerq_pkg::entry_type     entry,
   output logic                    below
);
   import lerq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      case (op)
         CELL_HOLD:       entry_in = entry_ff;
         CELL_LOAD_NEW:   entry_in = new_entry;
         CELL_FROM_LEFT:  entry_in = left_entry;
         CELL_FROM_RIGHT: entry_in = right_entry;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign below = ctrl.occupied && (entry_ff.track < ctrl.key);

endmodule
